// ===== rtl/core/utf8r_pkg.sv =====
// Shared types and character codes for the UTF-8 to RTF escape unit.
// No dependencies; imported by the decoder, the emitter and the top level.
package utf8r_pkg;

  // What an accepted item turns into on the output side
  typedef enum logic [1:0] {
    RUN_CHAR,   // plain ASCII character
    RUN_ESC,    // ASCII character with a backslash before it
    RUN_CODE    // \u<signed decimal>? escape
  } run_kind_t;

  typedef struct packed {
    run_kind_t   kind;
    logic [7:0]  chr;
    logic [15:0] code;
  } run_t;

  typedef struct packed {
    logic [2:0] pending;
    logic       skipping;
  } dec_status_t;

  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_ZERO   = 8'h30;

endpackage

// ===== rtl/core/utf8_to_rtf_escape_unit.sv =====
// UTF-8 to RTF escape unit: one input byte per item, escaped text out one byte per item.
// An accepted byte with output is loaded into the run register; its characters (two for an
// escaped ASCII byte, 4 to 9 for a code) then pass through the output register. A new byte
// is taken only when the run register is free or drains its last character; output can stall.
// Reset (rst, synchronous): clears decoder state and empties the run and output registers.
// Depends on utf8r_pkg, utf8r_decode, utf8r_emit.
module utf8_to_rtf_escape_unit
  import utf8r_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,   // in_text_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // out_run_last
);

  logic        accept;
  run_t        run;
  logic        run_hit;
  dec_status_t dec_status;
  logic        emit_busy;

  // An item enters whenever the run register is free or drains its last
  // character this cycle; the output register decouples the master side.
  assign accept = s_tvalid && s_tready;

  // Decode the byte against the sequence state; update state on accept.
  utf8r_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .in_byte  (s_tdata),
    .text_end (s_tlast),
    .run      (run),
    .run_hit  (run_hit),
    .status   (dec_status)
  );

  // Serialize the run: load it only when the item produces output.
  utf8r_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load_run   (run),
    .load       (accept && run_hit),
    .load_ready (s_tready),
    .busy       (emit_busy),
    .out_byte   (m_tdata),
    .out_last   (m_tlast),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready)
  );

  // End of string must leave the decoder idle.
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> dec_status.pending == 3'd0 && !dec_status.skipping)
    else $error("decoder state not cleared after end of string");

  // A running skip always has bytes left to drop.
  a_skip_pending: assert property (@(posedge clk) disable iff (rst)
    dec_status.skipping |-> dec_status.pending != 3'd0)
    else $error("skip active with no pending bytes");

  // An item with output must occupy the run register next cycle.
  a_run_loaded: assert property (@(posedge clk) disable iff (rst)
    accept && run_hit |=> emit_busy)
    else $error("accepted item with output was not loaded");

endmodule

// ===== rtl/core/utf8r_decode.sv =====
// UTF-8 sequence decoder: tracks lead/continuation state and classifies items.
// Depends on utf8r_pkg.
module utf8r_decode
  import utf8r_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        text_end,
  output run_t        run,
  output logic        run_hit,
  output dec_status_t status
);

  logic [2:0]  pending, pending_next;
  logic        skipping, skipping_next;
  logic [15:0] accum, accum_next;
  logic [2:0]  pend_dec;
  logic [2:0]  lead_ones;
  logic [15:0] code_ext;

  // Leading ones below bit 7 of a 0xF? byte
  always_comb begin
    priority if (!in_byte[3]) lead_ones = 3'd3;
    else if (!in_byte[2])     lead_ones = 3'd4;
    else if (!in_byte[1])     lead_ones = 3'd5;
    else if (!in_byte[0])     lead_ones = 3'd6;
    else                      lead_ones = 3'd7;
  end

  assign pend_dec = pending - 3'd1;
  assign code_ext = {accum[9:0], in_byte[5:0]};

  always_comb begin
    pending_next  = pending;
    skipping_next = skipping;
    accum_next    = accum;
    run_hit       = 1'b0;
    run.kind      = RUN_CHAR;
    run.chr       = in_byte;
    run.code      = code_ext;
    priority if (pending != 3'd0) begin
      pending_next = pend_dec;
      if (skipping) begin
        if (pend_dec == 3'd0) skipping_next = 1'b0;
      end else begin
        accum_next = code_ext;
        if (pend_dec == 3'd0) begin
          run_hit  = 1'b1;
          run.kind = RUN_CODE;
        end
      end
    end else if (!in_byte[7]) begin
      run_hit = 1'b1;
      if (in_byte == CH_LBRACE || in_byte == CH_RBRACE || in_byte == CH_BSL)
        run.kind = RUN_ESC;
    end else if (in_byte[7:4] == 4'hF) begin
      pending_next  = lead_ones;
      skipping_next = 1'b1;
    end else if (in_byte[5]) begin
      accum_next    = {12'd0, in_byte[3:0]};
      pending_next  = 3'd2;
      skipping_next = 1'b0;
    end else begin
      accum_next    = {11'd0, in_byte[4:0]};
      pending_next  = 3'd1;
      skipping_next = 1'b0;
    end
    // End of string: drop any partial sequence or running skip
    if (text_end) begin
      pending_next  = 3'd0;
      skipping_next = 1'b0;
      accum_next    = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 3'd0;
      skipping <= 1'b0;
      accum    <= 16'd0;
    end else if (accept) begin
      pending  <= pending_next;
      skipping <= skipping_next;
      accum    <= accum_next;
    end
  end

  assign status.pending  = pending;
  assign status.skipping = skipping;

endmodule

// ===== rtl/core/utf8r_emit.sv =====
// Output serializer: holds one run and emits its characters one per cycle while the output
// is not stalled, converting escape codes to signed decimal digit by digit. Depends on utf8r_pkg.
module utf8r_emit
  import utf8r_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  run_t       load_run,
  input  logic       load,
  output logic       load_ready,
  output logic       busy,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_valid,
  input  logic       out_ready
);

  typedef enum logic [2:0] {
    PH_BSL, PH_U, PH_MINUS, PH_DIGIT, PH_QMARK, PH_CHAR
  } phase_t;

  // j * 10^k for digit extraction
  localparam logic [16:0] DIGIT_STEP [5][10] = '{
    '{17'd0, 17'd1,     17'd2,     17'd3,     17'd4,
      17'd5, 17'd6,     17'd7,     17'd8,     17'd9},
    '{17'd0, 17'd10,    17'd20,    17'd30,    17'd40,
      17'd50, 17'd60,   17'd70,    17'd80,    17'd90},
    '{17'd0, 17'd100,   17'd200,   17'd300,   17'd400,
      17'd500, 17'd600, 17'd700,   17'd800,   17'd900},
    '{17'd0, 17'd1000,  17'd2000,  17'd3000,  17'd4000,
      17'd5000, 17'd6000, 17'd7000, 17'd8000, 17'd9000},
    '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000,
      17'd50000, 17'd60000, 17'd70000, 17'd80000, 17'd90000}
  };

  logic        run_valid;
  phase_t      phase, phase_nx, load_phase;
  run_kind_t   kind;
  logic [7:0]  chr;
  logic        neg;
  logic [15:0] mag, mag_nx, load_mag;
  logic [2:0]  k, k_nx, top_k;
  logic [16:0] mag17;
  logic [3:0]  digit;
  logic        step, is_last;
  logic [7:0]  ch;

  assign step  = run_valid && (!out_valid || out_ready);
  assign mag17 = {1'b0, mag};

  // Digit at position k: count of multiples of 10^k not above the remainder
  always_comb begin
    digit = 4'd0;
    for (int j = 1; j < 10; j++)
      digit = digit + {3'd0, (mag17 >= DIGIT_STEP[k][j])};
  end

  always_comb begin
    priority if (mag >= 16'd10000) top_k = 3'd4;
    else if (mag >= 16'd1000)      top_k = 3'd3;
    else if (mag >= 16'd100)       top_k = 3'd2;
    else if (mag >= 16'd10)        top_k = 3'd1;
    else                           top_k = 3'd0;
  end

  always_comb begin
    phase_nx = phase;
    k_nx     = k;
    mag_nx   = mag;
    is_last  = 1'b0;
    ch       = chr;
    unique case (phase)
      PH_BSL: begin
        ch       = CH_BSL;
        phase_nx = (kind == RUN_ESC) ? PH_CHAR : PH_U;
      end
      PH_U: begin
        ch       = CH_U;
        k_nx     = top_k;
        phase_nx = neg ? PH_MINUS : PH_DIGIT;
      end
      PH_MINUS: begin
        ch       = CH_MINUS;
        phase_nx = PH_DIGIT;
      end
      PH_DIGIT: begin
        ch     = CH_ZERO + {4'd0, digit};
        mag_nx = 16'(mag17 - DIGIT_STEP[k][digit]);
        if (k == 3'd0) phase_nx = PH_QMARK;
        else           k_nx     = k - 3'd1;
      end
      PH_QMARK: begin
        ch      = CH_QMARK;
        is_last = 1'b1;
      end
      default: begin
        ch      = chr;
        is_last = 1'b1;
      end
    endcase
  end

  assign load_ready = !run_valid || (step && is_last);
  assign load_phase = (load_run.kind == RUN_CHAR) ? PH_CHAR : PH_BSL;
  assign load_mag   = load_run.code[15] ? (~load_run.code + 16'd1) : load_run.code;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      phase     <= PH_CHAR;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
        out_byte  <= ch;
        out_last  <= is_last;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (load && load_ready) begin
        run_valid <= 1'b1;
        phase     <= load_phase;
        kind      <= load_run.kind;
        chr       <= load_run.chr;
        neg       <= load_run.code[15];
        mag       <= load_mag;
      end else if (step) begin
        if (is_last) run_valid <= 1'b0;
        phase <= phase_nx;
        k     <= k_nx;
        mag   <= mag_nx;
      end
    end
  end

  assign busy = run_valid;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for utf8_to_rtf_escape_unit: directed table, then random UTF-8 text.
// Predicts the escaped output stream in-line and compares every output item.
// Depends on utf8r_pkg and the utf8_to_rtf_escape_unit RTL.
module tb_top
  import utf8r_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // One expected output character and its end-of-run flag
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
  } rtf_char_t;
  typedef rtf_char_t rtf_run_t[$];

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;   // [7:0] in_byte
  logic       s_tlast = 1'b0;    // in_text_end
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;           // [7:0] out_byte
  logic       m_tlast;           // out_run_last

  utf8_to_rtf_escape_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // Reset once, released on a falling edge
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Stimulus list: byte, end-of-string flag, and an optional hand-written expectation
  logic [7:0] stim_byte[$];
  logic       stim_end[$];
  bit         stim_typed[$];
  string      stim_want[$];

  // Characters still owed by the block, oldest first
  rtf_char_t  rtf_out_q[$];

  // Decoder copy kept by the predictor
  logic [2:0]  dec_pending = '0;
  logic        dec_skip    = 1'b0;
  logic [15:0] dec_code    = '0;

  int faults    = 0;
  int in_count  = 0;
  int out_count = 0;

  task automatic note_fault(input string what);
    faults++;
    if (faults <= 10) $display("mismatch @%0t: %s", $time, what);
  endtask

  task automatic add_row(input logic [7:0] b, input logic e, input bit typed, input string want);
    stim_byte.push_back(b);
    stim_end.push_back(e);
    stim_typed.push_back(typed);
    stim_want.push_back(want);
  endtask

  // Work out the characters one input byte produces and advance the decoder copy
  function automatic rtf_run_t rtf_escape_predict(input logic [7:0] b, input logic e);
    rtf_run_t    run;
    logic [16:0] mag;
    logic [7:0]  dig[6];
    int          nd;
    int          cnt;
    bit          ones;
    run = {};
    if (dec_pending != 3'd0) begin
      dec_pending = dec_pending - 3'd1;
      if (dec_skip) begin
        if (dec_pending == 3'd0) dec_skip = 1'b0;
      end else begin
        dec_code = {dec_code[9:0], b[5:0]};
        if (dec_pending == 3'd0) begin
          // \u, optional minus, decimal magnitude, then '?'
          run.push_back('{CH_BSL, 1'b0});
          run.push_back('{CH_U, 1'b0});
          if (dec_code[15]) begin
            run.push_back('{CH_MINUS, 1'b0});
            mag = 17'h10000 - {1'b0, dec_code};
          end else begin
            mag = {1'b0, dec_code};
          end
          nd = 0;
          do begin
            dig[nd] = CH_ZERO + 8'(mag % 17'd10);
            mag = mag / 17'd10;
            nd++;
          end while (mag != 17'd0);
          while (nd > 0) begin
            nd--;
            run.push_back('{dig[nd], 1'b0});
          end
          run.push_back('{CH_QMARK, 1'b0});
        end
      end
    end else if (!b[7]) begin
      if (b == CH_LBRACE || b == CH_RBRACE || b == CH_BSL) run.push_back('{CH_BSL, 1'b0});
      run.push_back('{b, 1'b0});
    end else if (b[7:4] == 4'hF) begin
      // leading ones below bit 7 give the number of bytes to drop
      cnt  = 0;
      ones = 1'b1;
      for (int k = 6; k >= 0; k--) begin
        ones = ones & b[k];
        cnt += int'(ones);
      end
      dec_pending = 3'(cnt);
      dec_skip    = (cnt != 0);
    end else if (b[5]) begin
      dec_code    = {12'd0, b[3:0]};
      dec_pending = 3'd2;
      dec_skip    = 1'b0;
    end else begin
      dec_code    = {11'd0, b[4:0]};
      dec_pending = 3'd1;
      dec_skip    = 1'b0;
    end
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    if (e) begin
      dec_pending = '0;
      dec_skip    = 1'b0;
      dec_code    = '0;
    end
    return run;
  endfunction

  // Scoreboard: check the output item first, then queue what the accepted input item owes.
  // An input taken on this edge cannot show up on the output at the same edge.
  always @(posedge clk) begin
    rtf_run_t  run;
    rtf_char_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_count++;
        if (rtf_out_q.size() == 0) begin
          note_fault($sformatf("unexpected char %02h last %0b", m_tdata, m_tlast));
        end else begin
          want = rtf_out_q.pop_front();
          if (want.chr !== m_tdata || want.last !== m_tlast)
            note_fault($sformatf("char exp %02h/%0b got %02h/%0b",
                                 want.chr, want.last, m_tdata, m_tlast));
        end
      end
      if (s_tvalid && s_tready) begin
        run = rtf_escape_predict(s_tdata, s_tlast);
        // Hand-written rows replace the predicted run; the decoder copy still advances
        if (stim_typed[in_count]) begin
          run = {};
          for (int i = 0; i < stim_want[in_count].len(); i++)
            run.push_back('{stim_want[in_count][i], 1'b0});
          if (run.size() > 0) run[run.size()-1].last = 1'b1;
        end
        foreach (run[i]) rtf_out_q.push_back(run[i]);
        in_count++;
      end
    end
  end

  // Sender: build the stimulus, then offer it with random gaps
  initial begin
    int         useful;
    int         kind;
    int         n_cont;
    int         gap;
    int         drain;
    bit         calm;
    logic [7:0] b;
    logic       e;

    // Directed table: pass-through, escapes, codes, drops and cut-off sequences
    add_row(8'h41, 1'b0, 1, "A");
    add_row(8'h00, 1'b0, 0, "");
    add_row(8'h7F, 1'b0, 0, "");
    add_row(CH_LBRACE, 1'b0, 1, "\\{");
    add_row(CH_RBRACE, 1'b0, 1, "\\}");
    add_row(CH_BSL, 1'b0, 1, "\\\\");
    add_row(8'hC3, 1'b0, 1, "");
    add_row(8'hA9, 1'b0, 1, "\\u233?");
    // bit 15 set: most negative decimal
    add_row(8'hE8, 1'b0, 1, "");
    add_row(8'h80, 1'b0, 1, "");
    add_row(8'h80, 1'b0, 1, "\\u-32768?");
    // an ASCII byte while a sequence is open counts as a continuation
    add_row(8'hC2, 1'b0, 1, "");
    add_row(CH_LBRACE, 1'b0, 1, "\\u187?");
    // stray continuation byte acting as a 3-byte lead
    add_row(8'hA0, 1'b0, 0, "");
    add_row(8'hFF, 1'b0, 0, "");
    add_row(8'hFF, 1'b0, 0, "");
    // 4-byte sequence dropped whole
    add_row(8'hF0, 1'b0, 1, "");
    add_row(8'h80, 1'b0, 1, "");
    add_row(8'h80, 1'b0, 1, "");
    add_row(8'h80, 1'b0, 1, "");
    // end of string cuts a long drop short
    add_row(8'hFF, 1'b0, 1, "");
    add_row(8'h41, 1'b1, 1, "");
    // cut-off 3-byte sequence, then a lead byte carrying the end flag
    add_row(8'hE2, 1'b0, 1, "");
    add_row(8'h82, 1'b1, 1, "");
    add_row(8'hC3, 1'b1, 1, "");
    add_row(8'h42, 1'b1, 1, "B");

    // Random text: mostly well-formed sequences, some noise and cut-off ones
    useful = 0;
    while (useful < 450) begin
      kind = $urandom_range(0, 9);
      e    = ($urandom_range(0, 7) == 0);
      case (kind)
        0, 1, 2: begin
          case ($urandom_range(0, 5))
            0:       b = CH_LBRACE;
            1:       b = CH_RBRACE;
            2:       b = CH_BSL;
            default: b = 8'($urandom_range(0, 127));
          endcase
          add_row(b, e, 0, "");
          useful++;
        end
        3, 4, 5, 6: begin
          // 2- or 3-byte code; leads come from the proper range or the stray range
          if (kind < 5) begin
            b      = ($urandom_range(0, 3) == 0) ? 8'h80 | 8'($urandom_range(0, 31))
                                                 : 8'hC0 | 8'($urandom_range(0, 31));
            n_cont = 1;
          end else begin
            b      = ($urandom_range(0, 3) == 0) ? 8'hA0 | 8'($urandom_range(0, 31))
                                                 : 8'hE0 | 8'($urandom_range(0, 15));
            n_cont = 2;
          end
          add_row(b, 1'b0, 0, "");
          for (int i = 0; i < n_cont; i++) begin
            b = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h80 | 8'($urandom_range(0, 63));
            add_row(b, (i == n_cont - 1) ? e : 1'b0, 0, "");
          end
          useful += n_cont + 1;
        end
        7: begin
          // long sequence: drop the lead and its count of followers
          b = 8'($urandom_range(240, 255));
          add_row(b, 1'b0, 0, "");
          n_cont = 0;
          for (int k = 6; k >= 0 && b[k]; k--) n_cont++;
          for (int i = 0; i < n_cont; i++)
            add_row(8'($urandom), (i == n_cont - 1) ? e : 1'b0, 0, "");
          useful += n_cont + 1;
        end
        8: begin
          // cut-off sequence: lead plus at most one follower, end flag on the last
          b      = 8'($urandom_range(128, 255));
          n_cont = $urandom_range(0, 1);
          add_row(b, (n_cont == 0), 0, "");
          if (n_cont == 1) add_row(8'($urandom), 1'b1, 0, "");
          useful += n_cont + 1;
        end
        default: begin
          add_row(8'($urandom), e, 0, "");
          useful++;
        end
      endcase
    end

    wait (!rst);
    @(negedge clk);
    calm = 1'b0;
    foreach (stim_byte[i]) begin
      // switch now and then between back-to-back and gappy stretches
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= stim_byte[i];
      s_tlast  <= stim_end[i];
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      @(negedge clk);
    end
    s_tvalid <= 1'b0;

    // Drain: wait for every owed character, then keep watching to catch extras
    drain = 0;
    while (rtf_out_q.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (rtf_out_q.size() != 0)
      note_fault($sformatf("%0d chars never arrived", rtf_out_q.size()));
    if (faults == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Receiver: random stalls, calm stretches, and one long hold-off to back up the input
  initial begin
    int hold;
    bit held;
    bit calm;
    held = 1'b0;
    calm = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = ~calm;
      if (!held && out_count >= 120) begin
        hold = 400;
        held = 1'b1;
      end else begin
        hold = calm ? 0 : $urandom_range(0, 12);
      end
      if (hold > 0) begin
        m_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
